FILE: hdl/ctt_pkg.sv
package ctt_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int ITERATIONS_DEF   = 15;

  localparam int CFG_W  = 16;
  localparam int ANG_W  = 19;
  localparam int TURN_W = 16;
  localparam int Z_W    = 18;
  localparam int UNF_W  = 21;
  localparam int OUT_W  = 40;

  localparam logic [CFG_W-1:0] CENTER_OFFSET_RST = 16'd10000;

  localparam logic signed [UNF_W-1:0] QUARTER_TURN  = 21'sd90000;
  localparam logic signed [UNF_W-1:0] HALF_TURN     = 21'sd180000;
  localparam logic signed [UNF_W-1:0] NEG_HALF_TURN = -21'sd180000;
  localparam logic signed [UNF_W-1:0] THREE_Q_TURN  = 21'sd270000;
  localparam logic signed [UNF_W-1:0] FULL_TURN     = 21'sd360000;

  localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7fff;
  localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

  typedef logic [2:0] oct_t;

  localparam oct_t OCT_SWAP = 3'b001;
  localparam oct_t OCT_XNEG = 3'b010;
  localparam oct_t OCT_YNEG = 3'b100;

  localparam oct_t OCT_PLAIN          = 3'd0;
  localparam oct_t OCT_S              = 3'd1;
  localparam oct_t OCT_X              = 3'd2;
  localparam oct_t OCT_XS             = 3'd3;
  localparam oct_t OCT_Y              = 3'd4;
  localparam oct_t OCT_YS             = 3'd5;
  localparam oct_t OCT_YX             = 3'd6;
  localparam oct_t OCT_YXS            = 3'd7;

  // arctangent of 2^-(i+1) in millidegrees
  function automatic logic signed [Z_W-1:0] atan_mdeg(input logic [3:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      4'd0:    r = 18'sd26565;
      4'd1:    r = 18'sd14036;
      4'd2:    r = 18'sd7125;
      4'd3:    r = 18'sd3576;
      4'd4:    r = 18'sd1789;
      4'd5:    r = 18'sd895;
      4'd6:    r = 18'sd447;
      4'd7:    r = 18'sd223;
      4'd8:    r = 18'sd111;
      4'd9:    r = 18'sd55;
      4'd10:   r = 18'sd27;
      4'd11:   r = 18'sd13;
      4'd12:   r = 18'sd6;
      4'd13:   r = 18'sd3;
      4'd14:   r = 18'sd1;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/cordic_atan2_turn_tracker.sv
// throughput: one request per cycle when not stalled; input register, fold, two cordic passes, result register
// a stalled result register holds the whole pipe and drops s_tready in the same cycle
// reset: pipe empty, previous angle and turn count zero, center offset 10000
module cordic_atan2_turn_tracker #(
  parameter int SAMPLE_WIDTH = ctt_pkg::SAMPLE_WIDTH_DEF,
  parameter int ITERATIONS   = ctt_pkg::ITERATIONS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       s_tdata,  // cos_sample, sin_sample
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [ctt_pkg::OUT_W-1:0]                 m_tdata,  // angle_mdeg, turn_count
  input  logic                                      cfg_wen,
  input  logic [ctt_pkg::CFG_W-1:0]                 cfg_wdata
);

  localparam int XW      = SAMPLE_WIDTH + 3;
  localparam int FIRST_N = (ITERATIONS + 1) / 2;
  localparam int SECOND_N = ITERATIONS - FIRST_N;

  logic [ctt_pkg::CFG_W-1:0]              center_offset;
  logic [ctt_pkg::CFG_W+SAMPLE_WIDTH-1:0] offset_ext;
  logic                                   advance;
  logic                                   v_in;
  logic                                   v1;
  logic                                   v2;
  logic                                   v3;
  logic [SAMPLE_WIDTH-1:0]                cos_r;
  logic [SAMPLE_WIDTH-1:0]                sin_r;
  logic signed [XW-1:0]                   x1;
  logic signed [XW-1:0]                   y1;
  logic signed [XW-1:0]                   x2;
  logic signed [XW-1:0]                   y2;
  logic signed [XW-1:0]                   x3;
  logic signed [XW-1:0]                   y3;
  logic signed [ctt_pkg::Z_W-1:0]         z2;
  logic signed [ctt_pkg::Z_W-1:0]         z3;
  ctt_pkg::oct_t                          oct1;
  ctt_pkg::oct_t                          oct2;
  ctt_pkg::oct_t                          oct3;
  logic [ctt_pkg::ANG_W-1:0]              angle;
  logic signed [ctt_pkg::TURN_W-1:0]      turn;

  assign advance    = !m_tvalid || m_tready;
  assign s_tready   = advance;
  assign offset_ext = {{SAMPLE_WIDTH{1'b0}}, center_offset};

  always_ff @(posedge clk) begin
    if (rst) begin
      center_offset <= ctt_pkg::CENTER_OFFSET_RST;
    end else if (cfg_wen) begin
      center_offset <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in     <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      v_in     <= s_tvalid;
      v1       <= v_in;
      v2       <= v1;
      v3       <= v2;
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cos_r <= s_tdata[SAMPLE_WIDTH-1:0];
      sin_r <= s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
      oct2  <= oct1;
      oct3  <= oct2;
    end
  end

  ctt_fold #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_fold (
    .clk        (clk),
    .en         (advance),
    .cos_sample (cos_r),
    .sin_sample (sin_r),
    .offset     (offset_ext[SAMPLE_WIDTH-1:0]),
    .x          (x1),
    .y          (y1),
    .oct        (oct1)
  );

  ctt_cordic_stage #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .FIRST       (0),
    .COUNT       (FIRST_N)
  ) u_cordic_a (
    .clk  (clk),
    .en   (advance),
    .x_in (x1),
    .y_in (y1),
    .z_in ('0),
    .x    (x2),
    .y    (y2),
    .z    (z2)
  );

  ctt_cordic_stage #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .FIRST       (FIRST_N),
    .COUNT       (SECOND_N)
  ) u_cordic_b (
    .clk  (clk),
    .en   (advance),
    .x_in (x2),
    .y_in (y2),
    .z_in (z2),
    .x    (x3),
    .y    (y3),
    .z    (z3)
  );

  ctt_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .commit (advance && v3),
    .z_in   (z3),
    .oct    (oct3),
    .angle  (angle),
    .turn   (turn)
  );

  assign m_tdata = {5'b00000, turn, angle};

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("request taken while result stalled");

  a_turn_only_on_commit: assert property (@(posedge clk) disable iff (rst)
    !(advance && v3) |=> $stable(turn) && $stable(angle))
    else $error("tracker state moved without a committed sample");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[ctt_pkg::ANG_W-1:0] < 19'd360000))
    else $error("angle outside one revolution");

endmodule

FILE: hdl/ctt_fold.sv
module ctt_fold #(
  parameter int SAMPLE_WIDTH = ctt_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [SAMPLE_WIDTH-1:0]        cos_sample,
  input  logic [SAMPLE_WIDTH-1:0]        sin_sample,
  input  logic [SAMPLE_WIDTH-1:0]        offset,
  output logic signed [SAMPLE_WIDTH+2:0] x,
  output logic signed [SAMPLE_WIDTH+2:0] y,
  output ctt_pkg::oct_t                  oct
);

  logic signed [SAMPLE_WIDTH:0]   cx;
  logic signed [SAMPLE_WIDTH:0]   sy;
  logic signed [SAMPLE_WIDTH:0]   cx_abs;
  logic signed [SAMPLE_WIDTH:0]   sy_abs;
  logic [SAMPLE_WIDTH-1:0]        ax;
  logic [SAMPLE_WIDTH-1:0]        ay;
  logic                           swap;
  logic signed [SAMPLE_WIDTH+2:0] x_next;
  logic signed [SAMPLE_WIDTH+2:0] y_next;
  ctt_pkg::oct_t                  oct_next;

  always_comb begin
    cx     = $signed({1'b0, cos_sample}) - $signed({1'b0, offset});
    sy     = $signed({1'b0, sin_sample}) - $signed({1'b0, offset});
    cx_abs = cx[SAMPLE_WIDTH] ? -cx : cx;
    sy_abs = sy[SAMPLE_WIDTH] ? -sy : sy;
    ax     = cx_abs[SAMPLE_WIDTH-1:0];
    ay     = sy_abs[SAMPLE_WIDTH-1:0];
    swap   = ax < ay;
    x_next = $signed({3'b000, swap ? ay : ax});
    y_next = $signed({3'b000, swap ? ax : ay});
    oct_next = (sy[SAMPLE_WIDTH] ? ctt_pkg::OCT_YNEG : ctt_pkg::OCT_PLAIN)
             | (cx[SAMPLE_WIDTH] ? ctt_pkg::OCT_XNEG : ctt_pkg::OCT_PLAIN)
             | (swap ? ctt_pkg::OCT_SWAP : ctt_pkg::OCT_PLAIN);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x   <= x_next;
      y   <= y_next;
      oct <= oct_next;
    end
  end

endmodule

FILE: hdl/ctt_cordic_stage.sv
module ctt_cordic_stage #(
  parameter int SAMPLE_WIDTH = ctt_pkg::SAMPLE_WIDTH_DEF,
  parameter int FIRST        = 0,
  parameter int COUNT        = 8
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [SAMPLE_WIDTH+2:0] x_in,
  input  logic signed [SAMPLE_WIDTH+2:0] y_in,
  input  logic signed [ctt_pkg::Z_W-1:0] z_in,
  output logic signed [SAMPLE_WIDTH+2:0] x,
  output logic signed [SAMPLE_WIDTH+2:0] y,
  output logic signed [ctt_pkg::Z_W-1:0] z
);

  logic signed [SAMPLE_WIDTH+2:0] xs [COUNT+1];
  logic signed [SAMPLE_WIDTH+2:0] ys [COUNT+1];
  logic signed [ctt_pkg::Z_W-1:0] zs [COUNT+1];

  // one shift-add rotation per step, y of zero rotates the vector positive and lowers z
  always_comb begin
    xs[0] = x_in;
    ys[0] = y_in;
    zs[0] = z_in;
    for (int k = 0; k < COUNT; k++) begin
      if (ys[k] > 0) begin
        xs[k+1] = xs[k] + (ys[k] >>> (FIRST + k + 1));
        ys[k+1] = ys[k] - (xs[k] >>> (FIRST + k + 1));
        zs[k+1] = zs[k] + ctt_pkg::atan_mdeg(4'(FIRST + k));
      end else begin
        xs[k+1] = xs[k] - (ys[k] >>> (FIRST + k + 1));
        ys[k+1] = ys[k] + (xs[k] >>> (FIRST + k + 1));
        zs[k+1] = zs[k] - ctt_pkg::atan_mdeg(4'(FIRST + k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x <= xs[COUNT];
      y <= ys[COUNT];
      z <= zs[COUNT];
    end
  end

endmodule

FILE: hdl/ctt_tracker.sv
module ctt_tracker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              commit,
  input  logic signed [ctt_pkg::Z_W-1:0]    z_in,
  input  ctt_pkg::oct_t                     oct,
  output logic [ctt_pkg::ANG_W-1:0]         angle,
  output logic signed [ctt_pkg::TURN_W-1:0] turn
);

  logic signed [ctt_pkg::UNF_W-1:0]  zz;
  logic signed [ctt_pkg::UNF_W-1:0]  zu;
  logic signed [ctt_pkg::UNF_W-1:0]  zw;
  logic signed [ctt_pkg::UNF_W-1:0]  diff;
  logic [ctt_pkg::ANG_W-1:0]         angle_next;
  logic signed [ctt_pkg::TURN_W-1:0] turn_next;

  always_comb begin
    zz = ctt_pkg::UNF_W'(z_in);
    unique case (oct)
      ctt_pkg::OCT_PLAIN: zu = zz;
      ctt_pkg::OCT_S:     zu = ctt_pkg::QUARTER_TURN - zz;
      ctt_pkg::OCT_X:     zu = ctt_pkg::HALF_TURN - zz;
      ctt_pkg::OCT_XS:    zu = ctt_pkg::QUARTER_TURN + zz;
      ctt_pkg::OCT_Y:     zu = ctt_pkg::FULL_TURN - zz;
      ctt_pkg::OCT_YS:    zu = ctt_pkg::THREE_Q_TURN + zz;
      ctt_pkg::OCT_YX:    zu = ctt_pkg::HALF_TURN + zz;
      ctt_pkg::OCT_YXS:   zu = ctt_pkg::THREE_Q_TURN - zz;
    endcase
    if (zu < 0) begin
      zw = zu + ctt_pkg::FULL_TURN;
    end else if (zu >= ctt_pkg::FULL_TURN) begin
      zw = zu - ctt_pkg::FULL_TURN;
    end else begin
      zw = zu;
    end
    angle_next = zw[ctt_pkg::ANG_W-1:0];
    diff = $signed(ctt_pkg::UNF_W'(angle)) - $signed(ctt_pkg::UNF_W'(angle_next));
    turn_next = turn;
    if (diff > ctt_pkg::HALF_TURN) begin
      if (turn != ctt_pkg::TURN_MAX) begin
        turn_next = turn + 16'sd1;
      end
    end else if (diff < ctt_pkg::NEG_HALF_TURN) begin
      if (turn != ctt_pkg::TURN_MIN) begin
        turn_next = turn - 16'sd1;
      end
    end
  end

  // the angle register doubles as the previous angle
  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
      turn  <= '0;
    end else if (commit) begin
      angle <= angle_next;
      turn  <= turn_next;
    end
  end

endmodule

FILE: tb/sv/tb_cordic_atan2_turn_tracker.sv
module tb_cordic_atan2_turn_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ATAN_STEP_MDEG [0:15] = '{
    26565, 14036, 7125, 3576, 1789, 895, 447, 223,
    111, 55, 27, 13, 6, 3, 1, 0
  };
  localparam real DEG_TO_RAD = 3.14159265358979 / 180.0;
  localparam int HOLD_CYCLES = 300;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;  // cos_sample, sin_sample
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [39:0] m_tdata;         // angle_mdeg, turn_count
  logic        cfg_wen   = 1'b0;
  logic [15:0] cfg_wdata = '0;

  bit rx_stall_en = 1'b0;
  bit hold_req    = 1'b0;

  class angle_turn_scoreboard;
    logic [ctt_pkg::CFG_W-1:0]  offset;
    logic [ctt_pkg::ANG_W-1:0]  last_angle;
    int                         turns;
    logic [ctt_pkg::ANG_W-1:0]  angle_q[$];
    logic [ctt_pkg::TURN_W-1:0] turn_q[$];
    int                         errors;

    function new();
      offset     = ctt_pkg::CENTER_OFFSET_RST;
      last_angle = '0;
      turns      = 0;
      errors     = 0;
    endfunction

    function int outstanding();
      return angle_q.size();
    endfunction

    // fold to first octant, vectoring cordic, unfold and wrap
    function logic [ctt_pkg::ANG_W-1:0] octant_cordic_angle(logic [15:0] c,
                                                            logic [15:0] s);
      int            x, y, z, dx, dy, t;
      ctt_pkg::oct_t oct;
      x   = int'({16'd0, c}) - int'({16'd0, offset});
      y   = int'({16'd0, s}) - int'({16'd0, offset});
      z   = 0;
      oct = ctt_pkg::OCT_PLAIN;
      if (y < 0) begin
        oct = oct | ctt_pkg::OCT_YNEG;
        y = -y;
      end
      if (x < 0) begin
        oct = oct | ctt_pkg::OCT_XNEG;
        x = -x;
      end
      if (x < y) begin
        oct = oct | ctt_pkg::OCT_SWAP;
        t = x;
        x = y;
        y = t;
      end
      for (int i = 0; i < ctt_pkg::ITERATIONS_DEF; i++) begin
        dx = y >>> (i + 1);
        dy = x >>> (i + 1);
        if (y > 0) begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_STEP_MDEG[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_STEP_MDEG[i];
        end
      end
      case (oct)
        ctt_pkg::OCT_S:   z = int'(ctt_pkg::QUARTER_TURN) - z;
        ctt_pkg::OCT_X:   z = int'(ctt_pkg::HALF_TURN) - z;
        ctt_pkg::OCT_XS:  z = int'(ctt_pkg::QUARTER_TURN) + z;
        ctt_pkg::OCT_Y:   z = int'(ctt_pkg::FULL_TURN) - z;
        ctt_pkg::OCT_YS:  z = z + int'(ctt_pkg::THREE_Q_TURN);
        ctt_pkg::OCT_YX:  z = z + int'(ctt_pkg::HALF_TURN);
        ctt_pkg::OCT_YXS: z = int'(ctt_pkg::THREE_Q_TURN) - z;
        default: ;
      endcase
      z = z % int'(ctt_pkg::FULL_TURN);
      if (z < 0) z = z + int'(ctt_pkg::FULL_TURN);
      return z[ctt_pkg::ANG_W-1:0];
    endfunction

    function void note_sample(logic [31:0] d);
      logic [ctt_pkg::ANG_W-1:0] ang;
      int                        diff;
      ang  = octant_cordic_angle(d[15:0], d[31:16]);
      diff = int'({13'd0, last_angle}) - int'({13'd0, ang});
      if (diff > int'(ctt_pkg::HALF_TURN)) begin
        if (turns < int'(ctt_pkg::TURN_MAX)) turns++;
      end else if (diff < int'(ctt_pkg::NEG_HALF_TURN)) begin
        if (turns > int'(ctt_pkg::TURN_MIN)) turns--;
      end
      last_angle = ang;
      angle_q.push_back(ang);
      turn_q.push_back(turns[ctt_pkg::TURN_W-1:0]);
    endfunction

    function void check_result(logic [39:0] d);
      logic [ctt_pkg::ANG_W-1:0]  exp_angle;
      logic [ctt_pkg::TURN_W-1:0] exp_turn;
      if (angle_q.size() == 0) begin
        $error("result with no request pending: angle_mdeg %0d turn_count %0d",
               d[18:0], $signed(d[34:19]));
        errors++;
        return;
      end
      exp_angle = angle_q.pop_front();
      exp_turn  = turn_q.pop_front();
      if (d[18:0] !== exp_angle) begin
        $error("angle_mdeg: expected %0d, got %0d", exp_angle, d[18:0]);
        errors++;
      end
      if (d[34:19] !== exp_turn) begin
        $error("turn_count: expected %0d, got %0d", $signed(exp_turn), $signed(d[34:19]));
        errors++;
      end
    endfunction
  endclass

  angle_turn_scoreboard sb = new();

  cordic_atan2_turn_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_sample(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  // receiver: always ready, random ready/stall runs, or one long hold-off on request
  initial begin
    int n;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!rx_stall_en) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
        m_tready <= 1'b1;
        repeat (n) @(posedge clk);
        n = $urandom_range(1, 6);
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [15:0] clamp_sample(real v);
    if (v < 0.0) return 16'd0;
    if (v > 65535.0) return 16'hffff;
    return 16'(int'(v));
  endfunction

  task automatic send_request(input logic [15:0] c, input logic [15:0] s);
    s_tvalid <= 1'b1;
    s_tdata  <= {s, c};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic pause_sender(input int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_center_offset(input logic [15:0] v);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    sb.offset = v;
  endtask

  // three points 120 degrees apart around offset 32768, one lap per loop pass
  task automatic turn_sweep(input int laps, input bit upward);
    for (int k = 0; k < laps; k++) begin
      if (upward) begin
        send_request(16'd22768, 16'd50089);
        send_request(16'd22768, 16'd15447);
      end else begin
        send_request(16'd22768, 16'd15447);
        send_request(16'd22768, 16'd50089);
      end
      send_request(16'd52768, 16'd32768);
    end
  endtask

  task automatic random_phase(input int n_items);
    int          done, burst, mode, radius, gap;
    real         spin, stride;
    logic [15:0] c, s, off;
    done = 0;
    spin = real'($urandom_range(0, 359));
    off  = sb.offset;
    while (done < n_items) begin
      burst  = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      mode   = $urandom_range(0, 9);
      radius = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(100, 40000);
      stride = real'($urandom_range(0, 340)) - 170.0;
      for (int k = 0; k < burst && done < n_items; k++) begin
        if (mode < 6) begin
          spin = spin + stride + real'($urandom_range(0, 20)) - 10.0;
          c = clamp_sample(real'(off) + real'(radius) * $cos(spin * DEG_TO_RAD));
          s = clamp_sample(real'(off) + real'(radius) * $sin(spin * DEG_TO_RAD));
        end else if (mode < 8) begin
          c = 16'($urandom);
          s = 16'($urandom);
        end else if (mode == 8) begin
          c = off + 16'($urandom_range(0, 6)) - 16'd3;
          s = off + 16'($urandom_range(0, 6)) - 16'd3;
        end else begin
          case ($urandom_range(0, 2))
            0: c = 16'd0;
            1: c = 16'hffff;
            default: c = off;
          endcase
          case ($urandom_range(0, 2))
            0: s = 16'd0;
            1: s = 16'hffff;
            default: s = off;
          endcase
        end
        send_request(c, s);
        done++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) pause_sender(gap);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset offset of 10000; first request is compared against angle zero
    rx_stall_en = 1'b1;
    send_request(16'd10000, 16'd0);
    send_request(16'd10000, 16'd10000);
    send_request(16'd20000, 16'd10000);
    send_request(16'd0,     16'd10000);
    send_request(16'd10000, 16'd30000);
    send_request(16'd30000, 16'd30000);
    send_request(16'd30000, 16'd15000);
    send_request(16'd15000, 16'd30000);
    send_request(16'd0,     16'd13000);
    send_request(16'd7000,  16'd19000);
    send_request(16'd19000, 16'd7000);
    send_request(16'd13000, 16'd1000);
    send_request(16'd1000,  16'd7000);
    send_request(16'd7000,  16'd1000);
    send_request(16'd0,     16'd0);
    send_request(16'hffff,  16'hffff);
    send_request(16'd0,     16'hffff);
    send_request(16'hffff,  16'd0);
    send_request(16'hffff,  16'd10000);
    send_request(16'd20000, 16'd9000);
    send_request(16'd20000, 16'd11000);
    send_request(16'd20000, 16'd9000);
    send_request(16'd10001, 16'd10000);
    send_request(16'd10000, 16'd9999);
    drain_results();

    // count a few turns up, then down below zero, then up again
    rx_stall_en = 1'b0;
    set_center_offset(16'd32768);
    turn_sweep(4, 1'b1);
    turn_sweep(7, 1'b0);
    turn_sweep(2, 1'b1);
    drain_results();

    rx_stall_en = 1'b1;
    set_center_offset(16'd0);
    hold_req = 1'b1;
    random_phase(300);
    drain_results();

    set_center_offset(16'hffff);
    random_phase(250);
    drain_results();

    set_center_offset(16'd10000);
    random_phase(300);
    drain_results();

    repeat (3) begin
      set_center_offset(16'($urandom));
      random_phase(230);
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/ctt_pkg.sv
hdl/ctt_fold.sv
hdl/ctt_cordic_stage.sv
hdl/ctt_tracker.sv
hdl/cordic_atan2_turn_tracker.sv
tb/sv/tb_cordic_atan2_turn_tracker.sv
